// ===== src/ddpi_pkg.sv =====
// shared types and constants for the differential drive pi pwm controller
package ddpi_pkg;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int ACC_W     = 52;
    localparam int MAG_W     = 40;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_PER_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EMF_GAIN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION_OFFSET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PER_VOLT    = 3'd6;

    localparam logic [23:0] RST_SPEED_PER_COUNT = 24'd10294;
    localparam logic [15:0] RST_TICK_PERIOD     = 16'd6554;
    localparam logic [31:0] RST_PROP_GAIN       = 32'd873791488;
    localparam logic [31:0] RST_INTEG_GAIN      = 32'd8738;
    localparam logic [31:0] RST_EMF_GAIN        = 32'd10192;
    localparam logic [19:0] RST_FRICTION_OFFSET = 20'd11141;
    localparam logic [23:0] RST_PWM_PER_VOLT    = 24'd1985939;

    localparam logic [6:0]  PWM_LIMIT = 7'd100;
    localparam logic [31:0] S32_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN   = 32'h8000_0000;

    typedef struct packed {
        logic [23:0] speed_per_count;
        logic [15:0] tick_period;
        logic [31:0] prop_gain;
        logic [31:0] integ_gain;
        logic [31:0] emf_gain;
        logic [19:0] friction_offset;
        logic [23:0] pwm_per_volt;
    } cfg_t;

endpackage

// ===== src/ddpi_mul.sv =====
// shared 32x32 unsigned multiplier with registered product
module ddpi_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= {32'd0, a} * {32'd0, b};
    end

    assign prod = prod_reg;

endmodule

// ===== src/ddpi_core.sv =====
// sequencer and datapath: both wheels through one shared multiplier
module ddpi_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ddpi_pkg::cfg_t       cfg,
    input  logic                 start,
    input  logic [31:0]          count_left,
    input  logic [31:0]          count_right,
    input  logic [31:0]          target_left,
    input  logic [31:0]          target_right,
    input  logic                 ack,
    output logic                 busy,
    output logic                 done,
    output logic [7:0]           pwm_left,
    output logic [7:0]           pwm_right,
    output logic [31:0]          speed_left,
    output logic [31:0]          speed_right
);

    import ddpi_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIFF,
        S_WAIT,
        S_SPEED,
        S_ERR,
        S_TICK,
        S_INTEG,
        S_PROP,
        S_KI,
        S_KB,
        S_FRIC,
        S_MAG,
        S_PLO,
        S_PHI,
        S_PWM,
        S_DONE
    } state_t;

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    logic        wheel_reg;
    logic [31:0] last_reg [2];
    logic [31:0] integ_reg [2];
    logic [7:0]  pwm_reg [2];
    logic [31:0] spd_reg [2];

    // datapath registers
    logic [31:0]      cnt_l_reg, cnt_r_reg, tgt_l_reg, tgt_r_reg;
    logic [31:0]      op_a_reg, op_b_reg;
    logic             neg_reg;
    logic [31:0]      speed_reg;
    logic [31:0]      err_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [MAG_W-1:0] mag_reg;
    logic             vneg_reg;
    logic [31:0]      pacc_reg;

    logic [63:0] prod;

    ddpi_mul u_mul (
        .clk  (clk),
        .a    (op_a_reg),
        .b    (op_b_reg),
        .prod (prod)
    );

    logic [31:0]       cnt_sel, tgt_sel, diff, diff_mag;
    logic [31:0]       speed_sat, err_sat, err_mag, integ_sat, integ_mag, speed_mag;
    logic signed [32:0] err_wide;
    logic [33:0]       step, integ_sum;
    logic [ACC_W-1:0]  term, acc_fric, acc_abs;
    logic [MAG_W-1:0]  mag_clamp;
    logic [32:0]       psum;
    logic [6:0]        pmag;
    logic [7:0]        pwm_val;

    always_comb
    begin
        cnt_sel  = wheel_reg ? cnt_r_reg : cnt_l_reg;
        tgt_sel  = wheel_reg ? tgt_r_reg : tgt_l_reg;
        diff     = cnt_sel - last_reg[wheel_reg];
        diff_mag = diff[31] ? 32'd0 - diff : diff;

        // signed speed from |diff| * scale
        if (!neg_reg)
            speed_sat = (prod > {32'd0, S32_MAX}) ? S32_MAX : prod[31:0];
        else
            speed_sat = (prod > {32'd0, S32_MIN}) ? S32_MIN : 32'd0 - prod[31:0];

        err_wide = $signed({tgt_sel[31], tgt_sel}) - $signed({speed_reg[31], speed_reg});
        if (err_wide[32] != err_wide[31])
            err_sat = err_wide[32] ? S32_MIN : S32_MAX;
        else
            err_sat = err_wide[31:0];
        err_mag = err_reg[31] ? 32'd0 - err_reg : err_reg;

        step      = neg_reg ? 34'd0 - {2'b00, prod[47:16]} : {2'b00, prod[47:16]};
        integ_sum = {{2{integ_reg[wheel_reg][31]}}, integ_reg[wheel_reg]} + step;
        if (integ_sum[33:31] != 3'b000 && integ_sum[33:31] != 3'b111)
            integ_sat = integ_sum[33] ? S32_MIN : S32_MAX;
        else
            integ_sat = integ_sum[31:0];
        integ_mag = integ_reg[wheel_reg][31] ? 32'd0 - integ_reg[wheel_reg]
                                             : integ_reg[wheel_reg];
        speed_mag = speed_reg[31] ? 32'd0 - speed_reg : speed_reg;

        // truncated-toward-zero q16.16 term
        term = neg_reg ? {ACC_W{1'b0}} - {4'd0, prod[63:16]} : {4'd0, prod[63:16]};

        if (acc_reg[ACC_W-1])
            acc_fric = acc_reg - {{(ACC_W-20){1'b0}}, cfg.friction_offset};
        else if (|acc_reg)
            acc_fric = acc_reg + {{(ACC_W-20){1'b0}}, cfg.friction_offset};
        else
            acc_fric = acc_reg;

        acc_abs   = acc_reg[ACC_W-1] ? {ACC_W{1'b0}} - acc_reg : acc_reg;
        mag_clamp = (|acc_abs[ACC_W-1:MAG_W]) ? {MAG_W{1'b1}} : acc_abs[MAG_W-1:0];

        // high part of mag times scale lands whole above bit 32
        psum    = {1'b0, prod[31:0]} + {1'b0, pacc_reg};
        pmag    = (psum > {26'd0, PWM_LIMIT}) ? PWM_LIMIT : psum[6:0];
        pwm_val = vneg_reg ? 8'd0 - {1'b0, pmag} : {1'b0, pmag};
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_DIFF;
            S_DIFF:  begin state_next = S_WAIT; ret_next = S_SPEED; end
            S_WAIT:  state_next = ret_reg;
            S_SPEED: state_next = S_ERR;
            S_ERR:   state_next = S_TICK;
            S_TICK:  begin state_next = S_WAIT; ret_next = S_INTEG; end
            S_INTEG: begin state_next = S_WAIT; ret_next = S_PROP; end
            S_PROP:  begin state_next = S_WAIT; ret_next = S_KI; end
            S_KI:    begin state_next = S_WAIT; ret_next = S_KB; end
            S_KB:    state_next = S_FRIC;
            S_FRIC:  state_next = S_MAG;
            S_MAG:   state_next = S_PLO;
            S_PLO:   begin state_next = S_WAIT; ret_next = S_PHI; end
            S_PHI:   begin state_next = S_WAIT; ret_next = S_PWM; end
            S_PWM:   state_next = wheel_reg ? S_DONE : S_DIFF;
            S_DONE:  if (ack) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            wheel_reg    <= 1'b0;
            last_reg[0]  <= 32'd0;
            last_reg[1]  <= 32'd0;
            integ_reg[0] <= 32'd0;
            integ_reg[1] <= 32'd0;
            pwm_reg[0]   <= 8'd0;
            pwm_reg[1]   <= 8'd0;
            spd_reg[0]   <= 32'd0;
            spd_reg[1]   <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            case (state_reg)
                S_IDLE:  wheel_reg <= 1'b0;
                S_DIFF:  last_reg[wheel_reg] <= cnt_sel;
                S_INTEG: integ_reg[wheel_reg] <= integ_sat;
                S_PWM:
                begin
                    pwm_reg[wheel_reg] <= pwm_val;
                    spd_reg[wheel_reg] <= speed_reg;
                    wheel_reg          <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cnt_l_reg <= count_left;
                cnt_r_reg <= count_right;
                tgt_l_reg <= target_left;
                tgt_r_reg <= target_right;
            end
            S_DIFF:
            begin
                op_a_reg <= diff_mag;
                op_b_reg <= {8'd0, cfg.speed_per_count};
                neg_reg  <= diff[31];
            end
            S_SPEED: speed_reg <= speed_sat;
            S_ERR:   err_reg <= err_sat;
            S_TICK:
            begin
                op_a_reg <= err_mag;
                op_b_reg <= {16'd0, cfg.tick_period};
                neg_reg  <= err_reg[31];
            end
            S_INTEG:
            begin
                op_a_reg <= err_mag;
                op_b_reg <= cfg.prop_gain;
            end
            S_PROP:
            begin
                acc_reg  <= term;
                op_a_reg <= integ_mag;
                op_b_reg <= cfg.integ_gain;
                neg_reg  <= integ_reg[wheel_reg][31];
            end
            S_KI:
            begin
                acc_reg  <= acc_reg + term;
                op_a_reg <= speed_mag;
                op_b_reg <= cfg.emf_gain;
                neg_reg  <= speed_reg[31];
            end
            S_KB:    acc_reg <= acc_reg + term;
            S_FRIC:  acc_reg <= acc_fric;
            S_MAG:
            begin
                mag_reg  <= mag_clamp;
                vneg_reg <= acc_reg[ACC_W-1];
            end
            S_PLO:
            begin
                op_a_reg <= mag_reg[31:0];
                op_b_reg <= {8'd0, cfg.pwm_per_volt};
            end
            S_PHI:
            begin
                pacc_reg <= prod[63:32];
                op_a_reg <= {{(64-MAG_W){1'b0}}, mag_reg[MAG_W-1:32]};
            end
            default: ;
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_DONE);
    assign pwm_left    = pwm_reg[0];
    assign pwm_right   = pwm_reg[1];
    assign speed_left  = spd_reg[0];
    assign speed_right = spd_reg[1];

endmodule

// ===== src/diff_drive_pi_pwm_control_unit.sv =====
// top level: configuration registers, request handshake and result register
//
// Two-wheel pi speed controller. One request per control tick carries the
// encoder count and the target speed of both wheels; one result carries the
// pwm duty (-100..100) and the measured speed of both wheels.
// Input channel: in_valid / in_stall, request taken when in_valid && !in_stall.
// Output channel: out_valid / out_stall, result taken when out_valid && !out_stall.
// A request runs through one shared 32x32 multiplier under a sequencer, one
// wheel after the other; a new request is not taken until the sequencer is
// back in idle. The multiplier and its wait states set the pace: seven products
// per wheel, each followed by a wait state. in_stall is high while a request
// is in work. A finished result waits in the output register; a new request
// may be taken while it waits, and the following result is held inside until
// the output register is free. Configuration is to be written through cfg_we /
// cfg_index / cfg_data while idle; the user must keep to this, as the block
// does not enforce it. Reset clears the stored counts and error integrals and
// restores register defaults; the first tick measures its count difference
// against zero.
module diff_drive_pi_pwm_control_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ddpi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ddpi_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [31:0]                  count_left,
    input  logic signed [31:0]                  count_right,
    input  logic signed [31:0]                  target_left,
    input  logic signed [31:0]                  target_right,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [7:0]                   pwm_left,
    output logic signed [7:0]                   pwm_right,
    output logic signed [31:0]                  speed_left,
    output logic signed [31:0]                  speed_right
);

    import ddpi_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_per_count <= RST_SPEED_PER_COUNT;
            cfg_reg.tick_period     <= RST_TICK_PERIOD;
            cfg_reg.prop_gain       <= RST_PROP_GAIN;
            cfg_reg.integ_gain      <= RST_INTEG_GAIN;
            cfg_reg.emf_gain        <= RST_EMF_GAIN;
            cfg_reg.friction_offset <= RST_FRICTION_OFFSET;
            cfg_reg.pwm_per_volt    <= RST_PWM_PER_VOLT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPEED_PER_COUNT: cfg_reg.speed_per_count <= cfg_data[23:0];
                REG_TICK_PERIOD:     cfg_reg.tick_period     <= cfg_data[15:0];
                REG_PROP_GAIN:       cfg_reg.prop_gain       <= cfg_data;
                REG_INTEG_GAIN:      cfg_reg.integ_gain      <= cfg_data;
                REG_EMF_GAIN:        cfg_reg.emf_gain        <= cfg_data;
                REG_FRICTION_OFFSET: cfg_reg.friction_offset <= cfg_data[19:0];
                REG_PWM_PER_VOLT:    cfg_reg.pwm_per_volt    <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    logic        core_busy, core_done, core_ack;
    logic [7:0]  core_pwm_l, core_pwm_r;
    logic [31:0] core_spd_l, core_spd_r;

    ddpi_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .start        (in_valid && !core_busy),
        .count_left   (count_left),
        .count_right  (count_right),
        .target_left  (target_left),
        .target_right (target_right),
        .ack          (core_ack),
        .busy         (core_busy),
        .done         (core_done),
        .pwm_left     (core_pwm_l),
        .pwm_right    (core_pwm_r),
        .speed_left   (core_spd_l),
        .speed_right  (core_spd_r)
    );

    logic        out_valid_reg;
    logic [7:0]  pwm_l_reg, pwm_r_reg;
    logic [31:0] spd_l_reg, spd_r_reg;

    // result moves on when the output register is empty or being drained
    assign core_ack = core_done && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (core_ack)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (core_ack)
        begin
            pwm_l_reg <= core_pwm_l;
            pwm_r_reg <= core_pwm_r;
            spd_l_reg <= core_spd_l;
            spd_r_reg <= core_spd_r;
        end
    end

    assign in_stall    = core_busy;
    assign out_valid   = out_valid_reg;
    assign pwm_left    = pwm_l_reg;
    assign pwm_right   = pwm_r_reg;
    assign speed_left  = spd_l_reg;
    assign speed_right = spd_r_reg;

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("sequencer not busy after a request was taken");

    a_result_from_core: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(core_done))
        else $error("result appeared without a finished computation");

    a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pwm_left <= 8'sd100) && (pwm_left >= -8'sd100)
                   && (pwm_right <= 8'sd100) && (pwm_right >= -8'sd100))
        else $error("pwm duty outside saturation limits");

endmodule
